[rtl/lcd_multiplex_waveform_sequencer_core_defines.svh]
// Assertion macros shared by the checker of the LCD waveform sequencer.
`ifndef LCD_MULTIPLEX_WAVEFORM_SEQUENCER_CORE_DEFINES_SVH
`define LCD_MULTIPLEX_WAVEFORM_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LCDM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcdm assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LCDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcdm assertion failed");

`endif

[rtl/lcdm_pkg.sv]
// Types, codes and waveform map tables of the LCD waveform sequencer.
`timescale 1ns / 1ps
package lcdm_pkg;

  localparam int unsigned SegWidth  = 24;
  localparam int unsigned MapWidth  = 27;
  localparam int unsigned DataRegs  = 12;

  // Input item modes.
  localparam logic [1:0] ModeTick   = 2'd0;
  localparam logic [1:0] ModeWrite  = 2'd1;
  localparam logic [1:0] ModeEnable = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegMuxMode   = 2'd0;
  localparam logic [1:0] RegWaveTypeB = 2'd1;
  localparam logic [1:0] RegSegEnable = 2'd2;

  // Octal maps, first phase in the most significant digit; [type][mux][line].
  localparam logic [MapWidth-1:0] ComMap [2][4][4] = '{
    '{
      '{27'o3, 27'o0, 27'o0, 27'o0},
      '{27'o321, 27'o2103, 27'o0, 27'o0},
      '{27'o32121, 27'o210321, 27'o212103, 27'o0},
      '{27'o3212121, 27'o21032121, 27'o21210321, 27'o21212103}
    },
    '{
      '{27'o3, 27'o0, 27'o0, 27'o0},
      '{27'o231, 27'o2013, 27'o0, 27'o0},
      '{27'o22311, 27'o202131, 27'o220113, 27'o0},
      '{27'o2223111, 27'o20221311, 27'o22021131, 27'o22201113}
    }
  };

  localparam logic [MapWidth-1:0] OnMap [2][4] = '{
    '{27'o30, 27'o3030, 27'o303030, 27'o30303030},
    '{27'o30, 27'o3300, 27'o333000, 27'o33330000}
  };

  localparam logic [MapWidth-1:0] OffMap [2][4] = '{
    '{27'o3, 27'o1212, 27'o121212, 27'o12121212},
    '{27'o3, 27'o1122, 27'o111222, 27'o11112222}
  };

  typedef struct packed {
    logic [1:0]          mux;
    logic                type_b;
    logic [SegWidth-1:0] seg_en;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] data_index;
    logic [7:0] data_value;
  } item_t;

  // Data registers and hold store are kept as one 24-bit row per common.
  typedef struct packed {
    logic [2:0]                phase;
    logic [3:0][SegWidth-1:0]  data;
    logic [3:0][SegWidth-1:0]  held;
    logic                      enable;
    logic                      running;
    logic                      open_w;
    logic                      fault;
    logic [1:0]                run_mux;
    logic                      run_b;
  } state_t;

  typedef struct packed {
    logic [7:0] com;
    logic [1:0] on_l;
    logic [1:0] off_l;
  } wave_t;

  typedef struct packed {
    logic [7:0]          com_levels;
    logic [SegWidth-1:0] seg_on;
    logic [1:0]          on_level;
    logic [1:0]          off_level;
    logic                frame_irq;
    logic                frame_done;
    logic                write_allowed;
    logic                write_error;
    logic                active;
  } result_t;

endpackage

[rtl/lcdm_cfg_regs.sv]
// Configuration register file of the LCD waveform sequencer.
`timescale 1ns / 1ps
module lcdm_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [1:0]           wr_index_i,
  input  logic [23:0]          wr_data_i,
  output lcdm_pkg::cfg_t       cfg_o
);
  import lcdm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        RegMuxMode:   cfg_q.mux    <= wr_data_i[1:0];
        RegWaveTypeB: cfg_q.type_b <= wr_data_i[0];
        RegSegEnable: cfg_q.seg_en <= wr_data_i[SegWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/lcdm_wave.sv]
// Bias level lookup for one phase from the type A and type B maps.
`timescale 1ns / 1ps
module lcdm_wave (
  input  logic                run_b_i,
  input  logic [1:0]          run_mux_i,
  input  logic [2:0]          phase_i,
  output lcdm_pkg::wave_t     wave_o
);
  import lcdm_pkg::*;

  logic [2:0] last_w;
  logic [2:0] digit_w;
  logic [4:0] shift_w;

  // The last phase of the frame is 2*mux+1; later phases read digit zero.
  assign last_w  = {run_mux_i, 1'b1};
  assign digit_w = (phase_i <= last_w) ? (last_w - phase_i) : 3'd0;
  assign shift_w = 5'({digit_w, 1'b0}) + 5'(digit_w);

  always_comb begin
    wave_o = '0;
    for (int l = 0; l < 4; l++) begin
      if (2'(l) <= run_mux_i) begin
        wave_o.com[2*l +: 2] = 2'(ComMap[run_b_i][run_mux_i][l] >> shift_w);
      end
    end
    wave_o.on_l  = 2'(OnMap[run_b_i][run_mux_i] >> shift_w);
    wave_o.off_l = 2'(OffMap[run_b_i][run_mux_i] >> shift_w);
  end

endmodule

[rtl/lcdm_step.sv]
// Next-state and result logic for one input item of the LCD sequencer.
`timescale 1ns / 1ps
module lcdm_step #(
  parameter int unsigned SEGMENTS = 24
) (
  input  lcdm_pkg::cfg_t      cfg_i,
  input  lcdm_pkg::item_t     item_i,
  input  lcdm_pkg::state_t    state_i,
  output lcdm_pkg::state_t    state_o,
  output lcdm_pkg::result_t   result_o
);
  import lcdm_pkg::*;

  localparam logic [SegWidth-1:0] SegMask = SegWidth'((64'd1 << SEGMENTS) - 64'd1);

  state_t     mid_w;
  wave_t      wave_w;
  logic       do_tick_w;
  logic [1:0] wr_row_w;
  logic [1:0] wr_byte_w;
  logic       wr_hit_w;

  // Data register number is common*3 + byte.
  always_comb begin
    wr_hit_w = (item_i.data_index < 4'(DataRegs));
    if (item_i.data_index >= 4'd9) begin
      wr_row_w  = 2'd3;
      wr_byte_w = 2'(item_i.data_index - 4'd9);
    end else if (item_i.data_index >= 4'd6) begin
      wr_row_w  = 2'd2;
      wr_byte_w = 2'(item_i.data_index - 4'd6);
    end else if (item_i.data_index >= 4'd3) begin
      wr_row_w  = 2'd1;
      wr_byte_w = 2'(item_i.data_index - 4'd3);
    end else begin
      wr_row_w  = 2'd0;
      wr_byte_w = item_i.data_index[1:0];
    end
  end

  // Item decode: writes, enable and start, everything but the tick itself.
  always_comb begin
    mid_w     = state_i;
    do_tick_w = 1'b0;
    case (item_i.mode)
      ModeTick: begin
        do_tick_w = state_i.running;
      end
      ModeWrite: begin
        if (wr_hit_w) begin
          if (state_i.open_w) begin
            mid_w.data[wr_row_w][{wr_byte_w, 3'b000} +: 8] = item_i.data_value;
          end else begin
            mid_w.fault = 1'b1;
          end
        end
      end
      ModeEnable: begin
        if (item_i.data_value[0] && !state_i.enable) begin
          mid_w.enable  = 1'b1;
          mid_w.run_mux = cfg_i.mux;
          mid_w.run_b   = cfg_i.type_b;
          mid_w.phase   = 3'd0;
          mid_w.held    = state_i.data;
          mid_w.running = 1'b1;
          if (!cfg_i.type_b) begin
            mid_w.open_w = 1'b1;
          end
          do_tick_w = 1'b1;
        end else if (!item_i.data_value[0]) begin
          mid_w.enable = 1'b0;
        end
      end
      default: ;
    endcase
  end

  lcdm_wave u_wave (
    .run_b_i   (mid_w.run_b),
    .run_mux_i (mid_w.run_mux),
    .phase_i   (mid_w.phase),
    .wave_o    (wave_w)
  );

  // Phase tick: levels, segment selects, mid-frame and end-of-frame events.
  always_comb begin
    logic [2:0] mux1;
    logic [1:0] sub;
    logic [3:0] np;
    logic [3:0] pn;
    mux1     = {1'b0, mid_w.run_mux} + 3'd1;
    np       = 4'({mid_w.run_mux, 1'b0}) + 4'd2;
    pn       = {1'b0, mid_w.phase} + 4'd1;
    state_o  = mid_w;
    result_o = '0;
    if (mid_w.run_b) begin
      sub = (mid_w.phase >= mux1) ? 2'(mid_w.phase - mux1) : mid_w.phase[1:0];
    end else begin
      sub = mid_w.phase[2:1];
    end
    if (do_tick_w) begin
      result_o.com_levels = wave_w.com;
      result_o.on_level   = wave_w.on_l;
      result_o.off_level  = wave_w.off_l;
      result_o.seg_on     = mid_w.held[sub] & cfg_i.seg_en & SegMask;
      if (mid_w.run_b && (mid_w.phase == mux1)) begin
        result_o.frame_irq = 1'b1;
        state_o.open_w     = 1'b1;
      end
      if (pn >= np) begin
        state_o.phase       = 3'd0;
        state_o.held        = mid_w.data;
        result_o.frame_done = 1'b1;
        if (!mid_w.enable) begin
          state_o.running = 1'b0;
        end
        if (mid_w.run_b) begin
          state_o.open_w = 1'b0;
        end
      end else begin
        state_o.phase = pn[2:0];
      end
    end
    result_o.write_allowed = state_o.open_w;
    result_o.write_error   = state_o.fault;
    result_o.active        = state_o.running;
  end

endmodule

[rtl/lcd_multiplex_waveform_sequencer_core.sv]
// Multiplexed LCD waveform sequencer: top level with item and result registers.
`timescale 1ns / 1ps
// The sequencer takes one transaction per clock cycle and returns exactly one
// result transaction for each transaction that it accepts: the item lands
// in an input register, one pass of decode, map lookup and frame bookkeeping
// runs between that register and the result register, and the result waits
// there until the sink takes it. While a result is stalled the input register
// can still take one more transaction, so the source sees stall only when both
// registers are full. A phase tick (mode 0) walks a frame of 2*(mux+1) phases
// and gives the bias level index of each common in use together with the on
// and off level indices and the selected segments; a data write (mode 1) is
// refused with a sticky error unless writes are open; mode 2 starts or stops
// the display, a start performing the first phase tick at once and a stop
// taking effect at the end of the current frame. Multiplex and waveform type
// are sampled at start; the segment enables apply on every tick. SEGMENTS
// sets how many of the 24 segment outputs the block drives; the rest read
// zero. Configuration writes are always ready and must only be issued while
// no transaction is in flight.
module lcd_multiplex_waveform_sequencer_core #(
  parameter int unsigned SEGMENTS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_mode_i,
  input  logic [3:0]  in_data_index_i,
  input  logic [7:0]  in_data_value_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_com_levels_o,
  output logic [23:0] out_seg_on_o,
  output logic [1:0]  out_on_level_o,
  output logic [1:0]  out_off_level_o,
  output logic        out_frame_irq_o,
  output logic        out_frame_done_o,
  output logic        out_write_allowed_o,
  output logic        out_write_error_o,
  output logic        out_active_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import lcdm_pkg::*;

  cfg_t    cfg_w;
  item_t   item_q;
  logic    in_valid_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_q;
  result_t res_d;
  logic    res_valid_q;
  logic    res_ready_w;
  logic    accept_w;
  logic    advance_w;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  lcdm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg_w)
  );

  // The result register frees up when it is empty or being taken this cycle.
  assign res_ready_w = !res_valid_q || !out_stall_i;
  assign advance_w   = in_valid_q && res_ready_w;
  assign in_stall_o  = in_valid_q && !res_ready_w;
  assign accept_w    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || res_ready_w) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      item_q <= '{mode: in_mode_i, data_index: in_data_index_i,
                  data_value: in_data_value_i};
    end
  end

  lcdm_step #(
    .SEGMENTS (SEGMENTS)
  ) u_step (
    .cfg_i    (cfg_w),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state moves only when its item passes into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_w) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready_w) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_w) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = res_valid_q;
  assign out_com_levels_o    = res_q.com_levels;
  assign out_seg_on_o        = res_q.seg_on;
  assign out_on_level_o      = res_q.on_level;
  assign out_off_level_o     = res_q.off_level;
  assign out_frame_irq_o     = res_q.frame_irq;
  assign out_frame_done_o    = res_q.frame_done;
  assign out_write_allowed_o = res_q.write_allowed;
  assign out_write_error_o   = res_q.write_error;
  assign out_active_o        = res_q.active;

endmodule

[rtl/lcdm_checker.sv]
// Port-level checker of the LCD waveform sequencer and its bind.
`timescale 1ns / 1ps
`include "lcd_multiplex_waveform_sequencer_core_defines.svh"
module lcdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_com_levels_o,
  input logic [23:0] out_seg_on_o,
  input logic        out_frame_irq_o,
  input logic        out_frame_done_o,
  input logic        out_write_allowed_o,
  input logic        out_write_error_o,
  input logic        out_active_o
);

  // A stalled result holds its payload.
  `LCDM_ASSERT_NEXT(a_res_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_com_levels_o) && $stable(out_seg_on_o) && $stable(out_active_o))

  // The block never stalls its source while the sink is taking results.
  `LCDM_ASSERT_NOW(a_no_stall_when_drained, !out_stall_i, !in_stall_o)

  // A refused write is remembered until reset.
  `LCDM_ASSERT_NEXT(a_error_sticky, out_valid_o && out_write_error_o, out_write_error_o)

  // Away from the frame end, the mid-frame interrupt always opens writes.
  `LCDM_ASSERT_NOW(a_irq_opens_writes, out_valid_o && out_frame_irq_o && !out_frame_done_o,
    out_write_allowed_o)

endmodule

bind lcd_multiplex_waveform_sequencer_core lcdm_checker u_lcdm_checker (.*);

[dv/lcd_multiplex_waveform_sequencer_core_test.sv]
// Self-checking testbench of the multiplexed LCD waveform sequencer core.
`timescale 1ns / 1ps
// Every accepted item is run through a behavioral model of the sequencer that
// lives in this file. The model covers the phase counter, the data registers,
// the hold store, the write window and the type A / type B level maps. Each
// prediction goes into a queue. Every result transaction is checked field by
// field against the oldest entry in that queue.
//
// The stimulus starts with a short scripted sequence. It covers ticks while
// stopped, the unused mode, writes outside the register range, a start, a
// redundant enable, a stop that only takes effect at frame end, a type B frame
// with its mid-frame interrupt, and a write refused while the window is closed.
// The random part then steps through all eight combinations of multiplex and
// waveform type. Most of its traffic is well-formed: the display is started,
// ticked, written and stopped, with some stray items mixed in.
//
// The source sends in bursts with random gaps. The sink stalls in stretches of
// its own: no stall, light, heavy and toggling. One long hold-off in the sink
// makes the block fill up and stall its input. One pause in the source lets
// every outstanding result drain before sending resumes.
module lcd_multiplex_waveform_sequencer_core_test;
  import lcdm_pkg::*;

  localparam int unsigned SEGMENTS = 24;
  localparam logic [23:0] SegMask = (SEGMENTS >= 24) ? 24'hFFFFFF : 24'((1 << SEGMENTS) - 1);
  // Mode 3 has no function; the block must leave its state alone.
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned PhaseItems = 212;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TimeoutNs = 3_000_000;

  typedef enum logic [2:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle,
    StallHold
  } stall_style_e;

  // One scripted step: a register write or an item, with an optional typed-in result.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [23:0] reg_val;
    item_t       item;
    bit          typed;
    result_t     want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_mode_i = '0;
  logic [3:0]  in_data_index_i = '0;
  logic [7:0]  in_data_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_com_levels_o;
  logic [23:0] out_seg_on_o;
  logic [1:0]  out_on_level_o;
  logic [1:0]  out_off_level_o;
  logic        out_frame_irq_o;
  logic        out_frame_done_o;
  logic        out_write_allowed_o;
  logic        out_write_error_o;
  logic        out_active_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  lcd_multiplex_waveform_sequencer_core #(
    .SEGMENTS(SEGMENTS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_mode_i          (in_mode_i),
    .in_data_index_i    (in_data_index_i),
    .in_data_value_i    (in_data_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_com_levels_o   (out_com_levels_o),
    .out_seg_on_o       (out_seg_on_o),
    .out_on_level_o     (out_on_level_o),
    .out_off_level_o    (out_off_level_o),
    .out_frame_irq_o    (out_frame_irq_o),
    .out_frame_done_o   (out_frame_done_o),
    .out_write_allowed_o(out_write_allowed_o),
    .out_write_error_o  (out_write_error_o),
    .out_active_o       (out_active_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Display model state: configuration, and everything the sequencer keeps.
  logic [1:0]  cfg_mux = '0;
  logic        cfg_type_b = 1'b0;
  logic [23:0] cfg_seg_en = '0;
  logic [2:0]  frame_phase = '0;
  logic [7:0]  seg_data [DataRegs] = '{default: '0};
  logic [7:0]  seg_shown [DataRegs] = '{default: '0};
  bit          disp_enable = 1'b0;
  bit          disp_running = 1'b0;
  bit          writes_open = 1'b0;
  bit          write_fault = 1'b0;
  logic [1:0]  run_mux = '0;
  bit          run_type_b = 1'b0;

  result_t     expected_drive [$];
  int unsigned mismatches = 0;
  bit          long_hold_req = 1'b0;
  script_row_t script [$];

  // The level maps are written in octal, one digit per phase, with the first
  // phase in the most significant digit.
  function automatic logic [23:0] com_wave(bit b, logic [1:0] mux, logic [1:0] line);
    case ({b, mux, line})
      5'b0_00_00: return 24'o3;
      5'b0_01_00: return 24'o321;
      5'b0_01_01: return 24'o2103;
      5'b0_10_00: return 24'o32121;
      5'b0_10_01: return 24'o210321;
      5'b0_10_10: return 24'o212103;
      5'b0_11_00: return 24'o3212121;
      5'b0_11_01: return 24'o21032121;
      5'b0_11_10: return 24'o21210321;
      5'b0_11_11: return 24'o21212103;
      5'b1_00_00: return 24'o3;
      5'b1_01_00: return 24'o231;
      5'b1_01_01: return 24'o2013;
      5'b1_10_00: return 24'o22311;
      5'b1_10_01: return 24'o202131;
      5'b1_10_10: return 24'o220113;
      5'b1_11_00: return 24'o2223111;
      5'b1_11_01: return 24'o20221311;
      5'b1_11_10: return 24'o22021131;
      5'b1_11_11: return 24'o22201113;
      default:    return '0;
    endcase
  endfunction

  function automatic logic [23:0] seg_wave(bit b, logic [1:0] mux, bit lit);
    case ({b, mux, lit})
      4'b0_00_1: return 24'o30;
      4'b0_01_1: return 24'o3030;
      4'b0_10_1: return 24'o303030;
      4'b0_11_1: return 24'o30303030;
      4'b1_00_1: return 24'o30;
      4'b1_01_1: return 24'o3300;
      4'b1_10_1: return 24'o333000;
      4'b1_11_1: return 24'o33330000;
      4'b0_00_0: return 24'o3;
      4'b0_01_0: return 24'o1212;
      4'b0_10_0: return 24'o121212;
      4'b0_11_0: return 24'o12121212;
      4'b1_00_0: return 24'o3;
      4'b1_01_0: return 24'o1122;
      4'b1_10_0: return 24'o111222;
      default:   return 24'o11112222;
    endcase
  endfunction

  // One waveform phase: the drive levels of this phase, followed by the
  // frame bookkeeping.
  function automatic result_t run_phase();
    result_t     r;
    int unsigned slots;
    int unsigned p;
    int unsigned shift;
    int unsigned sub;
    int unsigned line;
    logic [23:0] row;
    r = '0;
    slots = 2 * (int'(run_mux) + 1);
    p = frame_phase;
    shift = (p < slots) ? 3 * (slots - 1 - p) : 0;
    // Type B shows each common's data in both half frames; type A shows it in
    // two phases in a row.
    sub = run_type_b ? p % (int'(run_mux) + 1) : p / 2;
    for (line = 0; line <= run_mux; line++) begin
      r.com_levels[2*line +: 2] = 2'(com_wave(run_type_b, run_mux, 2'(line)) >> shift);
    end
    r.on_level = 2'(seg_wave(run_type_b, run_mux, 1'b1) >> shift);
    r.off_level = 2'(seg_wave(run_type_b, run_mux, 1'b0) >> shift);
    row = {seg_shown[3*sub+2], seg_shown[3*sub+1], seg_shown[3*sub]};
    r.seg_on = row & cfg_seg_en & SegMask;
    if (run_type_b && p == int'(run_mux) + 1) begin
      r.frame_irq = 1'b1;
      writes_open = 1'b1;
    end
    p++;
    if (p >= slots) begin
      p = 0;
      seg_shown = seg_data;
      r.frame_done = 1'b1;
      if (!disp_enable) disp_running = 1'b0;
      if (run_type_b) writes_open = 1'b0;
    end
    frame_phase = 3'(p);
    return r;
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t r;
    r = '0;
    case (it.mode)
      ModeTick: begin
        if (disp_running) r = run_phase();
      end
      ModeWrite: begin
        if (it.data_index < DataRegs) begin
          if (writes_open) seg_data[it.data_index] = it.data_value;
          else write_fault = 1'b1;
        end
      end
      ModeEnable: begin
        if (it.data_value[0] && !disp_enable) begin
          // A start latches the mode and then performs the first phase right away.
          disp_enable = 1'b1;
          run_mux = cfg_mux;
          run_type_b = cfg_type_b;
          frame_phase = '0;
          seg_shown = seg_data;
          disp_running = 1'b1;
          if (!run_type_b) writes_open = 1'b1;
          r = run_phase();
        end else if (!it.data_value[0]) begin
          disp_enable = 1'b0;
        end
      end
      default: ;
    endcase
    r.write_allowed = writes_open;
    r.write_error = write_fault;
    r.active = disp_running;
    return r;
  endfunction

  function automatic result_t flags_only(bit allowed, bit fault, bit act);
    result_t r;
    r = '0;
    r.write_allowed = allowed;
    r.write_error = fault;
    r.active = act;
    return r;
  endfunction

  function automatic script_row_t item_row(logic [1:0] m, logic [3:0] i, logic [7:0] v);
    script_row_t row;
    row = '{default: '0};
    row.item.mode = m;
    row.item.data_index = i;
    row.item.data_value = v;
    return row;
  endfunction

  function automatic script_row_t checked_row(logic [1:0] m, logic [3:0] i, logic [7:0] v,
                                              result_t w);
    script_row_t row;
    row = item_row(m, i, v);
    row.typed = 1'b1;
    row.want = w;
    return row;
  endfunction

  function automatic script_row_t reg_row(logic [1:0] r, logic [23:0] d);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = r;
    row.reg_val = d;
    return row;
  endfunction

  // Random traffic mostly follows the life of a display: it starts the
  // display, ticks it, writes data and now and then stops it.
  function automatic item_t next_item();
    item_t       it;
    int unsigned roll;
    it.mode = ModeTick;
    it.data_index = 4'($urandom);
    it.data_value = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (!disp_enable) begin
      if (roll < 70) begin
        it.mode = ModeEnable;
        it.data_value[0] = 1'b1;
      end else if (roll >= 85) begin
        it.mode = 2'($urandom);
      end
    end else begin
      if (roll >= 55 && roll < 78) begin
        it.mode = ModeWrite;
        if ($urandom_range(0, 7) != 0) it.data_index = 4'($urandom_range(0, DataRegs - 1));
      end else if (roll >= 78 && roll < 84) begin
        it.mode = ModeEnable;
        it.data_value[0] = 1'b0;
      end else if (roll >= 84 && roll < 90) begin
        it.mode = ModeEnable;
        it.data_value[0] = 1'b1;
      end else if (roll >= 90 && roll < 95) begin
        it.mode = ModeSpare;
      end
    end
    return it;
  endfunction

  task automatic compare_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  // Drives one item starting at a falling edge and holds it until it is
  // accepted. It returns at the next falling edge with valid still high.
  task automatic offer(item_t it, bit typed, result_t want);
    result_t predicted;
    in_valid_i = 1'b1;
    in_mode_i = it.mode;
    in_data_index_i = it.data_index;
    in_data_value_i = it.data_value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = apply_item(it);
    expected_drive.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      RegMuxMode:   cfg_mux = val[1:0];
      RegWaveTypeB: cfg_type_b = val[0];
      RegSegEnable: cfg_seg_en = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stops sending and waits until every predicted result has arrived, then
  // waits on so that the pipeline is empty as well.
  task automatic settle();
    in_valid_i = 1'b0;
    while (expected_drive.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Result monitor.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        $error("result transaction with no expected result pending");
      end else begin
        want = expected_drive.pop_front();
        compare_field("com_levels", 24'(want.com_levels), 24'(out_com_levels_o));
        compare_field("seg_on", want.seg_on, out_seg_on_o);
        compare_field("on_level", 24'(want.on_level), 24'(out_on_level_o));
        compare_field("off_level", 24'(want.off_level), 24'(out_off_level_o));
        compare_field("frame_irq", 24'(want.frame_irq), 24'(out_frame_irq_o));
        compare_field("frame_done", 24'(want.frame_done), 24'(out_frame_done_o));
        compare_field("write_allowed", 24'(want.write_allowed), 24'(out_write_allowed_o));
        compare_field("write_error", 24'(want.write_error), 24'(out_write_error_o));
        compare_field("active", 24'(want.active), 24'(out_active_o));
      end
    end
  end

  // The sink stalls in stretches, each with its own style. When a long
  // hold-off is requested, the sink keeps stall high and counts the cycles.
  initial begin
    stall_style_e style;
    int unsigned  stretch;
    @(posedge rst_ni);
    forever begin
      style = stall_style_e'($urandom_range(0, 3));
      stretch = $urandom_range(16, 120);
      if (long_hold_req) begin
        style = StallHold;
        stretch = HoldCycles;
        long_hold_req = 1'b0;
      end
      repeat (stretch) begin
        @(negedge clk_i);
        case (style)
          StallNone:   out_stall_i = 1'b0;
          StallLight:  out_stall_i = ($urandom_range(0, 3) == 0);
          StallHeavy:  out_stall_i = ($urandom_range(0, 9) < 7);
          StallToggle: out_stall_i = ~out_stall_i;
          default:     out_stall_i = 1'b1;
        endcase
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("lcd_multiplex_waveform_sequencer_core_test: errors");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned burst_left;
    int unsigned gap;
    logic [23:0] en;

    // Scripted part. Every row that shows no typed result is checked against
    // the model.
    script = '{
      // After reset nothing runs: ticks, the spare mode and out-of-range writes
      // all return zero drive and clear flags.
      checked_row(ModeTick, 4'h0, 8'h00, flags_only(1'b0, 1'b0, 1'b0)),
      checked_row(ModeSpare, 4'hA, 8'h55, flags_only(1'b0, 1'b0, 1'b0)),
      checked_row(ModeWrite, 4'hF, 8'hFF, flags_only(1'b0, 1'b0, 1'b0)),
      reg_row(RegSegEnable, 24'hFFFFFF),
      reg_row(RegMuxMode, 24'd3),
      reg_row(RegWaveTypeB, 24'd0),
      // Type A, 1/4 multiplex: start, fill a few registers, then stop in mid-frame.
      item_row(ModeEnable, 4'h0, 8'h01),
      item_row(ModeWrite, 4'h0, 8'hFF),
      item_row(ModeWrite, 4'hB, 8'h81),
      item_row(ModeWrite, 4'hC, 8'h00),
      item_row(ModeEnable, 4'h0, 8'hFF),
      item_row(ModeEnable, 4'h0, 8'hFE),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      // Type B, 1/2 multiplex: a full frame with the mid-frame interrupt. The
      // write window closes at frame end, so the last write is refused.
      reg_row(RegMuxMode, 24'd1),
      reg_row(RegWaveTypeB, 24'd1),
      item_row(ModeEnable, 4'h7, 8'h01),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      item_row(ModeTick, 4'h0, 8'h00),
      checked_row(ModeWrite, 4'h6, 8'h3C, flags_only(1'b0, 1'b1, 1'b1))
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        settle();
        write_register(script[k].reg_idx, script[k].reg_val);
      end else begin
        offer(script[k].item, script[k].typed, script[k].want);
      end
    end

    // Random part: eight phases that cover every combination of multiplex
    // and waveform type, with the segment enables at all ones, at all zeros
    // and random in between.
    for (phase = 0; phase < 8; phase++) begin
      settle();
      en = (phase == 5) ? 24'h0 : (phase % 3 == 0) ? 24'hFFFFFF : 24'($urandom);
      write_register(RegMuxMode, 24'(phase % 4));
      write_register(RegWaveTypeB, 24'(phase / 4));
      write_register(RegSegEnable, en);
      // In one phase the sink holds off long enough for the block to stall its input.
      if (phase == 2) long_hold_req = 1'b1;
      burst_left = 0;
      for (n = 0; n < PhaseItems; n++) begin
        // In one phase the source pauses halfway until everything has drained.
        if (phase == 5 && n == PhaseItems / 2) begin
          settle();
          burst_left = 0;
        end
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap != 0) begin
            in_valid_i = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
        offer(next_item(), 1'b0, '0);
        burst_left--;
      end
    end

    in_valid_i = 1'b0;
    while (expected_drive.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("lcd_multiplex_waveform_sequencer_core_test: clean");
    end else begin
      $display("lcd_multiplex_waveform_sequencer_core_test: errors");
    end
    $finish;
  end

endmodule
